// File: rtl/aikc_pkg.sv
// ---------------------------------------------------------------------------
// aikc_pkg: shared types and constants for the closest-solution arm IK core
// Holds the fixed-point constants, the arctangent table, the CORDIC step helpers
// and the Q12 rounding used by the top level and its CORDIC lanes.
// ---------------------------------------------------------------------------
package aikc_pkg;

  localparam int MAX_STAGES = 24;

  localparam logic signed [17:0] ZERO_POS = 18'sd7;
  localparam logic signed [15:0] ZERO_ANG = 16'sd1;
  localparam logic [25:0] ONE_Q24 = 26'd16777216;
  localparam logic [25:0] TOL_Q24 = 26'd168;

  localparam logic signed [33:0] PI_SRC_Q30      = 34'sd3373256577;
  localparam logic signed [33:0] HALF_PI_SRC_Q30 = 34'sd1686628289;
  localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;

  // register indexes
  localparam logic [1:0] REG_L1 = 2'd0;
  localparam logic [1:0] REG_L2 = 2'd1;
  localparam logic [1:0] REG_H  = 2'd2;

  // cordic working values: operands below 2^26, scaled by 2^24, with gain
  typedef logic signed [53:0] cval_t;
  typedef logic signed [33:0] ang_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    ang_t  z;
  } cord_t;

  function automatic ang_t atan_tab(input int i);
    case (i)
      0:  atan_tab = 34'sd843314856;
      1:  atan_tab = 34'sd497837829;
      2:  atan_tab = 34'sd263043836;
      3:  atan_tab = 34'sd133525158;
      4:  atan_tab = 34'sd67021686;
      5:  atan_tab = 34'sd33543515;
      6:  atan_tab = 34'sd16775850;
      7:  atan_tab = 34'sd8388437;
      8:  atan_tab = 34'sd4194282;
      9:  atan_tab = 34'sd2097149;
      10: atan_tab = 34'sd1048575;
      11: atan_tab = 34'sd524287;
      12: atan_tab = 34'sd262143;
      13: atan_tab = 34'sd131071;
      14: atan_tab = 34'sd65535;
      15: atan_tab = 34'sd32767;
      16: atan_tab = 34'sd16383;
      17: atan_tab = 34'sd8191;
      18: atan_tab = 34'sd4095;
      19: atan_tab = 34'sd2047;
      20: atan_tab = 34'sd1023;
      21: atan_tab = 34'sd511;
      22: atan_tab = 34'sd255;
      23: atan_tab = 34'sd127;
      default: atan_tab = '0;
    endcase
  endfunction

  // quadrant pre-rotation, a zero vector gets no pre-rotation and starts at angle zero
  function automatic cord_t cord_init(input logic signed [26:0] y,
                                      input logic signed [26:0] x);
    cord_t c;
    cval_t xs;
    cval_t ys;
    xs = cval_t'(x) <<< 24;
    ys = cval_t'(y) <<< 24;
    c.x = xs;
    c.y = ys;
    c.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        c.x = ys; c.y = -xs; c.z = HALF_PI_Q30;
      end else begin
        c.x = -ys; c.y = xs; c.z = -HALF_PI_Q30;
      end
    end
    return c;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t n;
    cval_t dx;
    cval_t dy;
    dx = c.x >>> i;
    dy = c.y >>> i;
    if (c.y >= 0) begin
      n.x = c.x + dy; n.y = c.y - dx; n.z = c.z + atan_tab(i);
    end else begin
      n.x = c.x - dy; n.y = c.y + dx; n.z = c.z - atan_tab(i);
    end
    return n;
  endfunction

  function automatic logic signed [15:0] to_q12(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'sd131072) >>> 18;
    if (r > 36'sd32767) to_q12 = 16'sh7fff;
    else if (r < -36'sd32768) to_q12 = 16'sh8000;
    else to_q12 = r[15:0];
  endfunction

endpackage

// File: rtl/aikc_sqrt.sv
// ---------------------------------------------------------------------------
// aikc_sqrt: pipelined floored integer square root
// One result bit per stage, with a tag word carried alongside each operand.
// ---------------------------------------------------------------------------
module aikc_sqrt #(
  parameter int IN_W  = 50,
  parameter int TAG_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [IN_W-1:0]            in_val,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_vld,
  output logic [(IN_W+1)/2-1:0]      out_root,
  output logic [TAG_W-1:0]           out_tag
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int NW = 2 * RW;

  logic [NW-1:0]    rem_r  [RW+1];
  logic [RW-1:0]    root_r [RW+1];
  logic [TAG_W-1:0] tag_r  [RW+1];
  logic             vld_r  [RW+1];

  always_comb begin
    rem_r[0]  = NW'(in_val);
    root_r[0] = '0;
    tag_r[0]  = in_tag;
    vld_r[0]  = in_vld;
  end

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [NW-1:0] trial_nxt;
    logic [NW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;
    always_comb begin
      // trial = (2*root + 2^b) * 2^b with root holding upper bits already
      trial_nxt = (NW'(root_r[k]) << (B + 1)) | (NW'(1) << (2 * B));
      if (rem_r[k] >= trial_nxt) begin
        rem_nxt  = rem_r[k] - trial_nxt;
        root_nxt = root_r[k] | (RW'(1) << B);
      end else begin
        rem_nxt  = rem_r[k];
        root_nxt = root_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        tag_r[k+1]  <= tag_r[k];
      end
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_tag  = tag_r[RW];
endmodule

// File: rtl/aikc_div.sv
// ---------------------------------------------------------------------------
// aikc_div: pipelined restoring divider
// Unsigned quotient one bit per stage; a tag word travels with each operand.
// ---------------------------------------------------------------------------
module aikc_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 34,
  parameter int Q_W   = 26,
  parameter int TAG_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [Q_W-1:0]     out_q,
  output logic               out_big,
  output logic [TAG_W-1:0]   out_tag
);
  // quotient bits above Q_W collapse into one saturating flag
  localparam int RW = DEN_W + 1;

  logic [NUM_W-1:0] num_r [Q_W+2];
  logic [DEN_W-1:0] den_r [Q_W+2];
  logic [RW-1:0]    rem_r [Q_W+2];
  logic [Q_W-1:0]   q_r   [Q_W+2];
  logic             big_r [Q_W+2];
  logic [TAG_W-1:0] tag_r [Q_W+2];
  logic             vld_r [Q_W+2];

  // first stage: is quotient >= 2^Q_W, and remainder of the top part
  logic [NUM_W-1:0] hi_part;
  logic             hi_big;
  always_comb begin
    hi_part = in_num >> Q_W;
    hi_big  = (NUM_W'(in_den) <= hi_part);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[1] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_vld;
    end
    if (en) begin
      num_r[1] <= in_num;
      den_r[1] <= in_den;
      rem_r[1] <= hi_big ? '0 : RW'(hi_part);
      q_r[1]   <= '0;
      big_r[1] <= hi_big;
      tag_r[1] <= in_tag;
    end
  end

  always_comb begin
    num_r[0] = '0; den_r[0] = '0; rem_r[0] = '0; q_r[0] = '0;
    big_r[0] = 1'b0; tag_r[0] = '0; vld_r[0] = 1'b0;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_st
    localparam int B = Q_W - k;
    logic [RW-1:0] sh_nxt;
    logic [RW-1:0] rem_nxt;
    logic          bit_nxt;
    always_comb begin
      sh_nxt  = {rem_r[k][RW-2:0], num_r[k][B]};
      bit_nxt = (sh_nxt >= RW'(den_r[k]));
      rem_nxt = bit_nxt ? sh_nxt - RW'(den_r[k]) : sh_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        num_r[k+1] <= num_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= rem_nxt;
        q_r[k+1]   <= q_r[k] | (Q_W'(bit_nxt) << B);
        big_r[k+1] <= big_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_vld = vld_r[Q_W+1];
  assign out_q   = q_r[Q_W+1];
  assign out_big = big_r[Q_W+1];
  assign out_tag = tag_r[Q_W+1];
endmodule

// File: rtl/arm_inverse_kinematics_closest_core.sv
// ---------------------------------------------------------------------------
// arm_inverse_kinematics_closest_core: closest-solution IK for a 3-joint arm
// Streams target points through square roots, divides, CORDIC atan2 stages
// and a four-way candidate pick.
// ---------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  in      | in_target_*, in_current_*_angle        | in_valid / in_ready
//  out     | out_*_angle, out_solution_index, ...   | out_valid / out_ready
//  cfg     | cfg_psel .. cfg_prdata                 | apb, pready tied high
//
// one word per cycle while the output is not stalled; the register stages run
// through the chain sqrt -> divide -> sqrt -> cordic, with the CORDIC stages
// capped at 24.
// the whole pipe advances together and halts while the output register is
// full and not taken; no word is dropped or repeated.
// reset is synchronous, clears the valid bits only and loads the cfg registers with defaults.
// ---------------------------------------------------------------------------
module arm_inverse_kinematics_closest_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] in_target_x,
  input  logic signed [17:0] in_target_y,
  input  logic signed [17:0] in_target_z,
  input  logic signed [15:0] in_current_base_angle,
  input  logic signed [15:0] in_current_shoulder_angle,
  input  logic signed [15:0] in_current_elbow_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_base_angle,
  output logic signed [15:0] out_shoulder_angle,
  output logic signed [15:0] out_elbow_angle,
  output logic [1:0]         out_solution_index,
  output logic               out_out_of_reach,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import aikc_pkg::*;

  localparam int NST = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

  // ---------------- configuration ----------------
  logic [15:0] l1_r, l2_r, h_r;
  logic [1:0]  reg_idx;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 16'd14418;
      l2_r <= 16'd9830;
      h_r  <= 16'd3604;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx)
        REG_L1:  l1_r <= cfg_pwdata[15:0];
        REG_L2:  l2_r <= cfg_pwdata[15:0];
        REG_H:   h_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_L1:  cfg_prdata = {16'd0, l1_r};
      REG_L2:  cfg_prdata = {16'd0, l2_r};
      REG_H:   cfg_prdata = {16'd0, h_r};
      default: cfg_prdata = '0;
    endcase
  end

  // whole pipe moves when the output slot is free or being taken
  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_vld_r;

  // ---------------- stage 1: zero replace ----------------
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [18:0] dz;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
  } ctx_t;

  logic  s1_vld_r;
  ctx_t  s1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_valid;
    if (en) begin
      s1_r.x  <= (in_target_x == 0) ? ZERO_POS : in_target_x;
      s1_r.y  <= (in_target_y == 0) ? ZERO_POS : in_target_y;
      s1_r.dz <= ((in_target_z == 0) ? 19'(ZERO_POS) : 19'(in_target_z))
                 - 19'(signed'({1'b0, h_r}));
      s1_r.c0 <= (in_current_base_angle == 0) ? ZERO_ANG : in_current_base_angle;
      s1_r.c1 <= (in_current_shoulder_angle == 0) ? ZERO_ANG : in_current_shoulder_angle;
      s1_r.c2 <= (in_current_elbow_angle == 0) ? ZERO_ANG : in_current_elbow_angle;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic        s2_vld_r;
  ctx_t        s2_r;
  logic [35:0] xx_r, yy_r;
  logic [37:0] zz_r;
  logic [31:0] l1sq_r, l2sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
    if (en) begin
      s2_r   <= s1_r;
      xx_r   <= 36'(s1_r.x * s1_r.x);
      yy_r   <= 36'(s1_r.y * s1_r.y);
      zz_r   <= 38'(s1_r.dz * s1_r.dz);
      l1sq_r <= l1_r * l1_r;
      l2sq_r <= l2_r * l2_r;
    end
  end

  // ---------------- stage 3: sums ----------------
  logic        s3_vld_r;
  ctx_t        s3_r;
  logic [36:0] a1sq_r;
  logic [38:0] d1sq_r;
  logic [31:0] l1sq3_r, l2sq3_r;
  logic [32:0] l12_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
    if (en) begin
      s3_r    <= s2_r;
      a1sq_r  <= 37'(xx_r) + 37'(yy_r);
      d1sq_r  <= 39'(xx_r) + 39'(yy_r) + 39'(zz_r);
      l1sq3_r <= l1sq_r;
      l2sq3_r <= l2sq_r;
      l12_r   <= 33'(l1_r * l2_r) << 1;
    end
  end

  // ---------------- roots of a1^2 and d1^2 ----------------
  // tag carries everything the later stages need
  typedef struct packed {
    ctx_t        c;
    logic [38:0] d1sq;
    logic [31:0] l1sq;
    logic [31:0] l2sq;
    logic [32:0] l12;
    logic [15:0] l1;
  } t1_t;
  localparam int T1_W = $bits(t1_t);

  t1_t t1_in;
  assign t1_in = '{c: s3_r, d1sq: d1sq_r, l1sq: l1sq3_r, l2sq: l2sq3_r,
                   l12: l12_r, l1: l1_r};

  logic        sqa_vld;
  logic [19:0] a1_root;
  logic [T1_W-1:0] sqa_tag;
  logic        sqd_vld;
  logic [19:0] d1_root;
  logic [T1_W-1:0] sqd_tag;

  aikc_sqrt #(.IN_W(40), .TAG_W(T1_W)) u_sqrt_a (
    .clk, .rst_n, .en, .in_vld(s3_vld_r), .in_val(40'(a1sq_r)), .in_tag(t1_in),
    .out_vld(sqa_vld), .out_root(a1_root), .out_tag(sqa_tag)
  );
  aikc_sqrt #(.IN_W(40), .TAG_W(1)) u_sqrt_d (
    .clk, .rst_n, .en, .in_vld(s3_vld_r), .in_val(40'(d1sq_r)), .in_tag(1'b0),
    .out_vld(sqd_vld), .out_root(d1_root), .out_tag(sqd_tag[0])
  );
  assign sqd_tag[T1_W-1:1] = '0;

  t1_t t1;
  assign t1 = t1_t'(sqa_tag);

  // ---------------- stage: numerators and denominators ----------------
  logic        s4_vld_r;
  t1_t         s4_r;
  logic [19:0] a1_4_r;
  logic signed [40:0] numa_r, numb_r;
  logic [35:0] dena_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (en) s4_vld_r <= sqa_vld;
    if (en) begin
      s4_r   <= t1;
      a1_4_r <= a1_root;
      numa_r <= 41'(t1.d1sq) + 41'(t1.l1sq) - 41'(t1.l2sq);
      numb_r <= 41'(t1.l1sq) + 41'(t1.l2sq) - 41'(t1.d1sq);
      dena_r <= 36'(t1.l1 * d1_root) << 1;
    end
  end

  // ---------------- cosine argument divides ----------------
  typedef struct packed {
    ctx_t        c;
    logic [19:0] a1;
    logic        nega;
    logic        negb;
    logic        za;
    logic        zb;
  } t2_t;
  localparam int T2_W = $bits(t2_t);

  logic [39:0] maga, magb;
  assign maga = numa_r[40] ? 40'(-numa_r) : 40'(numa_r);
  assign magb = numb_r[40] ? 40'(-numb_r) : 40'(numb_r);

  t2_t t2_in;
  assign t2_in = '{c: s4_r.c, a1: a1_4_r, nega: numa_r[40], negb: numb_r[40],
                   za: (dena_r == 0), zb: (s4_r.l12 == 0)};

  logic        dva_vld, dvb_vld;
  logic [25:0] qa, qb;
  logic        biga, bigb;
  logic [T2_W-1:0] dva_tag;
  logic        dvb_tag;

  aikc_div #(.NUM_W(64), .DEN_W(36), .Q_W(26), .TAG_W(T2_W)) u_div_a (
    .clk, .rst_n, .en, .in_vld(s4_vld_r), .in_num({maga, 24'd0}), .in_den(dena_r),
    .in_tag(t2_in), .out_vld(dva_vld), .out_q(qa), .out_big(biga), .out_tag(dva_tag)
  );
  aikc_div #(.NUM_W(64), .DEN_W(36), .Q_W(26), .TAG_W(1)) u_div_b (
    .clk, .rst_n, .en, .in_vld(s4_vld_r), .in_num({magb, 24'd0}),
    .in_den(36'(s4_r.l12)), .in_tag(1'b0),
    .out_vld(dvb_vld), .out_q(qb), .out_big(bigb), .out_tag(dvb_tag)
  );

  t2_t t2;
  assign t2 = t2_t'(dva_tag);

  // ---------------- clamp, flag, 1-c^2 ----------------
  function automatic logic [25:0] clampq(input logic [25:0] q, input logic big,
                                         input logic zden);
    if (zden || big || q > ONE_Q24) clampq = ONE_Q24;
    else clampq = q;
  endfunction

  logic [25:0] ca_mag, cb_mag;
  logic        fl_c;
  assign ca_mag = clampq(qa, biga, t2.za);
  assign cb_mag = clampq(qb, bigb, t2.zb);
  assign fl_c   = t2.za || t2.zb || biga || bigb
                  || (qa > ONE_Q24 + TOL_Q24) || (qb > ONE_Q24 + TOL_Q24);

  logic        s5_vld_r;
  ctx_t        s5_c_r;
  logic [19:0] s5_a1_r;
  logic signed [26:0] ca_r, cb_r;
  logic        s5_fl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (en) s5_vld_r <= dva_vld;
    if (en) begin
      s5_c_r  <= t2.c;
      s5_a1_r <= t2.a1;
      ca_r    <= t2.nega ? -27'(ca_mag) : 27'(ca_mag);
      cb_r    <= t2.negb ? -27'(cb_mag) : 27'(cb_mag);
      s5_fl_r <= fl_c;
    end
  end

  logic        s6_vld_r;
  ctx_t        s6_c_r;
  logic [19:0] s6_a1_r;
  logic signed [26:0] ca6_r, cb6_r;
  logic        s6_fl_r;
  logic [48:0] ra_r, rb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (en) s6_vld_r <= s5_vld_r;
    if (en) begin
      s6_c_r  <= s5_c_r;
      s6_a1_r <= s5_a1_r;
      ca6_r   <= ca_r;
      cb6_r   <= cb_r;
      s6_fl_r <= s5_fl_r;
      ra_r    <= 49'(49'h1_0000_0000_0000 - 49'(ca_r * ca_r));
      rb_r    <= 49'(49'h1_0000_0000_0000 - 49'(cb_r * cb_r));
    end
  end

  // ---------------- sines ----------------
  typedef struct packed {
    ctx_t        c;
    logic [19:0] a1;
    logic signed [26:0] ca;
    logic signed [26:0] cb;
    logic        fl;
  } t3_t;
  localparam int T3_W = $bits(t3_t);

  t3_t t3_in;
  assign t3_in = '{c: s6_c_r, a1: s6_a1_r, ca: ca6_r, cb: cb6_r, fl: s6_fl_r};

  logic        sna_vld;
  logic [24:0] sa, sb;
  logic [T3_W-1:0] sna_tag;
  logic        snb_vld, snb_tag;

  aikc_sqrt #(.IN_W(50), .TAG_W(T3_W)) u_sqrt_sa (
    .clk, .rst_n, .en, .in_vld(s6_vld_r), .in_val(50'(ra_r)), .in_tag(t3_in),
    .out_vld(sna_vld), .out_root(sa), .out_tag(sna_tag)
  );
  aikc_sqrt #(.IN_W(50), .TAG_W(1)) u_sqrt_sb (
    .clk, .rst_n, .en, .in_vld(s6_vld_r), .in_val(50'(rb_r)), .in_tag(1'b0),
    .out_vld(snb_vld), .out_root(sb), .out_tag(snb_tag)
  );

  t3_t t3;
  assign t3 = t3_t'(sna_tag);

  // ---------------- four cordic lanes: alpha, beta, delta, theta ----------------
  typedef struct packed {
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
    logic               fl;
  } t4_t;

  cord_t cd_r [4][NST+1];
  t4_t   ct_r [NST+1];
  logic  cv_r [NST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= sna_vld;
    if (en) begin
      cd_r[0][0] <= cord_init(27'(signed'({1'b0, sa})), t3.ca);
      cd_r[1][0] <= cord_init(27'(signed'({1'b0, sb})), t3.cb);
      cd_r[2][0] <= cord_init(27'(t3.c.dz), 27'(signed'({1'b0, t3.a1})));
      cd_r[3][0] <= cord_init(27'(t3.c.y), 27'(t3.c.x));
      ct_r[0]    <= '{c0: t3.c.c0, c1: t3.c.c1, c2: t3.c.c2, fl: t3.fl};
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_cord
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (en) cv_r[i+1] <= cv_r[i];
      if (en) begin
        cd_r[0][i+1] <= cord_step(cd_r[0][i], i);
        cd_r[1][i+1] <= cord_step(cd_r[1][i], i);
        cd_r[2][i+1] <= cord_step(cd_r[2][i], i);
        cd_r[3][i+1] <= cord_step(cd_r[3][i], i);
        ct_r[i+1] <= ct_r[i];
      end
    end
  end

  ang_t alpha, beta, delta, th;
  assign alpha = cd_r[0][NST].z;
  assign beta  = cd_r[1][NST].z;
  assign delta = cd_r[2][NST].z;
  assign th    = cd_r[3][NST].z;

  // ---------------- candidates, rounded ----------------
  logic signed [35:0] ad, amd;
  assign ad  = 36'(alpha) + 36'(delta);
  assign amd = 36'(alpha) - 36'(delta);

  logic signed [15:0] tb0, tb1, sh0, sh1, sh2, sh3, el0, el1;
  assign tb0 = to_q12(36'(th) + 36'(PI_SRC_Q30));
  assign tb1 = to_q12(36'(th));
  assign sh0 = to_q12(36'(HALF_PI_SRC_Q30) - ad);
  assign sh1 = to_q12(-36'(HALF_PI_SRC_Q30) + ad);
  assign sh2 = to_q12(-36'(HALF_PI_SRC_Q30) - amd);
  assign sh3 = to_q12(36'(HALF_PI_SRC_Q30) + amd);
  assign el0 = to_q12(36'(PI_SRC_Q30) - 36'(beta));
  assign el1 = to_q12(-36'(PI_SRC_Q30) + 36'(beta));

  logic        s7_vld_r;
  t4_t         s7_t_r;
  logic signed [15:0] cb_r7 [4], cs_r7 [4], ce_r7 [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (en) s7_vld_r <= cv_r[NST];
    if (en) begin
      s7_t_r   <= ct_r[NST];
      cb_r7[0] <= tb0; cs_r7[0] <= sh0; ce_r7[0] <= el0;
      cb_r7[1] <= tb1; cs_r7[1] <= sh1; ce_r7[1] <= el1;
      cb_r7[2] <= tb1; cs_r7[2] <= sh2; ce_r7[2] <= el0;
      cb_r7[3] <= tb0; cs_r7[3] <= sh3; ce_r7[3] <= el1;
    end
  end

  // ---------------- distances ----------------
  function automatic logic [16:0] absd(input logic signed [15:0] a,
                                       input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    absd = d[16] ? 17'(-d) : 17'(d);
  endfunction

  logic        s8_vld_r;
  t4_t         s8_t_r;
  logic signed [15:0] cb_r8 [4], cs_r8 [4], ce_r8 [4];
  logic [18:0] dist_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else if (en) s8_vld_r <= s7_vld_r;
    if (en) begin
      s8_t_r <= s7_t_r;
      for (int i = 0; i < 4; i++) begin
        cb_r8[i]  <= cb_r7[i];
        cs_r8[i]  <= cs_r7[i];
        ce_r8[i]  <= ce_r7[i];
        dist_r[i] <= 19'(absd(cb_r7[i], s7_t_r.c0)) + 19'(absd(cs_r7[i], s7_t_r.c1))
                     + 19'(absd(ce_r7[i], s7_t_r.c2));
      end
    end
  end

  // ---------------- pick and output register ----------------
  logic [1:0]  best;
  logic [18:0] bd;
  always_comb begin
    best = 2'd0;
    bd   = dist_r[0];
    for (int i = 1; i < 4; i++) begin
      if (dist_r[i] < bd) begin
        bd   = dist_r[i];
        best = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= s8_vld_r;
    if (en) begin
      out_base_angle     <= cb_r8[best];
      out_shoulder_angle <= cs_r8[best];
      out_elbow_angle    <= ce_r8[best];
      out_solution_index <= best;
      out_out_of_reach   <= s8_t_r.fl;
    end
  end

endmodule

// File: rtl/aikc_checker.sv
// ---------------------------------------------------------------------------
// aikc_checker: port-level checks for the arm IK core
// Watches the result channel and the register port.
// ---------------------------------------------------------------------------
module aikc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_solution_index,
  input logic [15:0] out_base_angle,
  input logic        cfg_pready
);
  // a held word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_base_angle)
                                && $stable(out_solution_index))
    else $error("result word changed while stalled");

  // input side stalls only while a result is stuck
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind arm_inverse_kinematics_closest_core aikc_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_solution_index,
  .out_base_angle, .cfg_pready
);
